### rtl/tqvg_pkg.sv
// Shared constants, codes and types of the tile quad vertex generator.
`default_nettype none

package tqvg_pkg;

   // Map, tile and fixed-point geometry.
   localparam int MAP_SIDE    = 1024;
   localparam int TILE_PIXELS = 64;
   localparam int FRAC_BITS   = 10;

   // Field widths of the item and result channels.
   localparam int COL_W   = 10;
   localparam int ID_W    = 16;
   localparam int ATLAS_W = 12;
   localparam int SPAN_W  = 4;
   localparam int POS_W   = 28;
   localparam int TEX_W   = 24;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Flip modes.
   typedef enum logic [1:0] {
      FLIP_NONE = 2'd0,
      FLIP_H    = 2'd1,
      FLIP_V    = 2'd2,
      FLIP_BOTH = 2'd3
   } flip_type;

   // Corner codes in emission order.
   typedef enum logic [1:0] {
      CORNER_TL = 2'd0,
      CORNER_TR = 2'd1,
      CORNER_BR = 2'd2,
      CORNER_BL = 2'd3
   } corner_type;

   // One classified tile as it waits for the back part.
   typedef struct packed {
      logic [POS_W-1:0] px0;
      logic [POS_W-1:0] px1;
      logic [POS_W-1:0] py0;
      logic [POS_W-1:0] py1;
      logic [TEX_W-1:0] tu0;
      logic [TEX_W-1:0] tu1;
      logic [TEX_W-1:0] tv0;
      logic [TEX_W-1:0] tv1;
      flip_type         flip;
      logic [1:0]       turns;
   } quad_type;

endpackage

`default_nettype wire

### rtl/tile_quad_vertex_generator_unit.sv
// Top level of the tile quad vertex generator: front, queue and back parts.
// An accepted tile is written into the queue, and its first vertex is then registered in the result register.
// One vertex per cycle leaves through the single result register while rsp_stall is low; a tile gives four.
// Empty or off-map tiles are taken from the input and give no vertices.
// The front takes items while the two-entry queue has room.
// Reset is synchronous and clears the queue pointers and fill count, corner counter and result valid.
`default_nettype none

module tile_quad_vertex_generator_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [tqvg_pkg::COL_W-1:0]       req_tile_col,
   input  wire logic [tqvg_pkg::COL_W-1:0]       req_tile_row,
   input  wire logic [tqvg_pkg::ID_W-1:0]        req_tile_id,
   input  wire logic [tqvg_pkg::ATLAS_W-1:0]     req_atlas_x,
   input  wire logic [tqvg_pkg::ATLAS_W-1:0]     req_atlas_y,
   input  wire logic [tqvg_pkg::ATLAS_W-1:0]     req_atlas_w,
   input  wire logic [tqvg_pkg::ATLAS_W-1:0]     req_atlas_h,
   input  wire logic                             req_span_on,
   input  wire logic [tqvg_pkg::SPAN_W-1:0]      req_span_w,
   input  wire logic [tqvg_pkg::SPAN_W-1:0]      req_span_h,
   input  wire logic [1:0]                       req_flip_mode,
   input  wire logic [1:0]                       req_quarter_turns,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [1:0]                            rsp_corner,
   output logic signed [tqvg_pkg::POS_W-1:0]     rsp_screen_x,
   output logic signed [tqvg_pkg::POS_W-1:0]     rsp_screen_y,
   output logic signed [tqvg_pkg::TEX_W-1:0]     rsp_tex_u,
   output logic signed [tqvg_pkg::TEX_W-1:0]     rsp_tex_v,
   output logic                                  rsp_last
);
   import tqvg_pkg::*;

   quad_type queue_data;
   quad_type queue_head;
   logic     queue_push;
   logic     queue_pop;
   logic     queue_empty;
   logic     queue_full;

   // Classification and edge computation.
   tqvg_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_tile_col      (req_tile_col),
      .req_tile_row      (req_tile_row),
      .req_tile_id       (req_tile_id),
      .req_atlas_x       (req_atlas_x),
      .req_atlas_y       (req_atlas_y),
      .req_atlas_w       (req_atlas_w),
      .req_atlas_h       (req_atlas_h),
      .req_span_on       (req_span_on),
      .req_span_w        (req_span_w),
      .req_span_h        (req_span_h),
      .req_flip_mode     (req_flip_mode),
      .req_quarter_turns (req_quarter_turns),
      .queue_full        (queue_full),
      .queue_push        (queue_push),
      .queue_data        (queue_data)
   );

   // Decoupling queue.
   tqvg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_data),
      .pop       (queue_pop),
      .head      (queue_head),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   // Vertex emission.
   tqvg_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (queue_head),
      .empty        (queue_empty),
      .pop          (queue_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_corner   (rsp_corner),
      .rsp_screen_x (rsp_screen_x),
      .rsp_screen_y (rsp_screen_y),
      .rsp_tex_u    (rsp_tex_u),
      .rsp_tex_v    (rsp_tex_v),
      .rsp_last     (rsp_last)
   );

   // The queue is never written while full.
   assert property (@(posedge clock) disable iff (reset) queue_push |-> !queue_full)
      else $error("tile pushed into a full queue");

   // A delivered vertex that is not the last is followed at once by the next corner.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last)
      |=> (rsp_valid && rsp_corner == 2'($past(rsp_corner) + 2'd1)))
      else $error("quad vertices not emitted back to back");

   // The last flag marks exactly the bottom-left corner.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_corner == CORNER_BL)))
      else $error("last flag on wrong corner");

   // No result is shown right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

`default_nettype wire

### rtl/tqvg_front.sv
// Front part: accepts tile items, drops empty and off-map ones and computes quad edges.
`default_nettype none

module tqvg_front (
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [tqvg_pkg::COL_W-1:0]   req_tile_col,
   input  wire logic [tqvg_pkg::COL_W-1:0]   req_tile_row,
   input  wire logic [tqvg_pkg::ID_W-1:0]    req_tile_id,
   input  wire logic [tqvg_pkg::ATLAS_W-1:0] req_atlas_x,
   input  wire logic [tqvg_pkg::ATLAS_W-1:0] req_atlas_y,
   input  wire logic [tqvg_pkg::ATLAS_W-1:0] req_atlas_w,
   input  wire logic [tqvg_pkg::ATLAS_W-1:0] req_atlas_h,
   input  wire logic                         req_span_on,
   input  wire logic [tqvg_pkg::SPAN_W-1:0]  req_span_w,
   input  wire logic [tqvg_pkg::SPAN_W-1:0]  req_span_h,
   input  wire logic [1:0]                   req_flip_mode,
   input  wire logic [1:0]                   req_quarter_turns,
   input  wire logic                         queue_full,
   output logic                              queue_push,
   output tqvg_pkg::quad_type                queue_data
);
   import tqvg_pkg::*;

   localparam logic [31:0]      MAP_LIMIT = 32'(MAP_SIDE);
   localparam logic [POS_W-1:0] TILE_POS  = POS_W'(TILE_PIXELS);
   localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1);
   localparam logic [TEX_W-1:0] TEX_ONE   = TEX_W'(1);

   logic             accept;
   logic             keep;
   logic [POS_W-1:0] col_pix;
   logic [POS_W-1:0] row_pix;
   logic [POS_W-1:0] quad_w;
   logic [POS_W-1:0] quad_h;

   // An item is taken whenever the queue has room; empty and off-map tiles are dropped.
   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign keep       = (req_tile_id != '0) && (32'(req_tile_col) < MAP_LIMIT)
                       && (32'(req_tile_row) < MAP_LIMIT);
   assign queue_push = accept && keep;

   // Quad size in pixels: atlas rectangle or whole tiles.
   assign col_pix = POS_W'(req_tile_col) * TILE_POS;
   assign row_pix = POS_W'(req_tile_row) * TILE_POS;
   assign quad_w  = req_span_on ? POS_W'(req_span_w) * TILE_POS : POS_W'(req_atlas_w);
   assign quad_h  = req_span_on ? POS_W'(req_span_h) * TILE_POS : POS_W'(req_atlas_h);

   // Screen edges widened and atlas edges shrunk by one LSB.
   always_comb begin
      queue_data.px0   = (col_pix << FRAC_BITS) - POS_ONE;
      queue_data.py0   = (row_pix << FRAC_BITS) - POS_ONE;
      queue_data.px1   = ((col_pix + quad_w) << FRAC_BITS) + POS_ONE;
      queue_data.py1   = ((row_pix + quad_h) << FRAC_BITS) + POS_ONE;
      queue_data.tu0   = (TEX_W'(req_atlas_x) << FRAC_BITS) + TEX_ONE;
      queue_data.tv0   = (TEX_W'(req_atlas_y) << FRAC_BITS) + TEX_ONE;
      queue_data.tu1   = ((TEX_W'(req_atlas_x) + TEX_W'(req_atlas_w)) << FRAC_BITS)
                         - TEX_ONE;
      queue_data.tv1   = ((TEX_W'(req_atlas_y) + TEX_W'(req_atlas_h)) << FRAC_BITS)
                         - TEX_ONE;
      queue_data.flip  = flip_type'(req_flip_mode);
      queue_data.turns = req_quarter_turns;
   end

endmodule

`default_nettype wire

### rtl/tqvg_queue.sv
// Short queue of classified tiles between the front and back parts.
`default_nettype none

module tqvg_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tqvg_pkg::quad_type push_data,
   input  wire logic               pop,
   output tqvg_pkg::quad_type      head,
   output logic                    empty,
   output logic                    full
);
   import tqvg_pkg::*;

   quad_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates; pointers wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/tqvg_back.sv
// Back part: walks the four corners of the head tile into the result register.
`default_nettype none

module tqvg_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire tqvg_pkg::quad_type               head,
   input  wire logic                             empty,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [1:0]                            rsp_corner,
   output logic signed [tqvg_pkg::POS_W-1:0]     rsp_screen_x,
   output logic signed [tqvg_pkg::POS_W-1:0]     rsp_screen_y,
   output logic signed [tqvg_pkg::TEX_W-1:0]     rsp_tex_u,
   output logic signed [tqvg_pkg::TEX_W-1:0]     rsp_tex_v,
   output logic                                  rsp_last
);
   import tqvg_pkg::*;

   corner_type       corner_ff;
   corner_type       corner_in;
   logic             valid_ff;
   logic             valid_in;
   corner_type       out_corner_ff;
   logic [POS_W-1:0] sx_ff;
   logic [POS_W-1:0] sy_ff;
   logic [TEX_W-1:0] tu_ff;
   logic [TEX_W-1:0] tv_ff;
   logic             out_ready;
   logic             fire;
   logic [1:0]       rot;
   logic [1:0]       src;
   logic [POS_W-1:0] sx;
   logic [POS_W-1:0] sy;
   logic [TEX_W-1:0] tu;
   logic [TEX_W-1:0] tv;

   // One vertex leaves per cycle while the result register can move.
   assign out_ready = !valid_ff || !rsp_stall;
   assign fire      = out_ready && !empty;
   assign pop       = fire && (corner_ff == CORNER_BL);
   assign corner_in = fire ? corner_type'(corner_ff + 2'd1) : corner_ff;
   assign valid_in  = out_ready ? fire : valid_ff;

   // Atlas corner chosen by rotation and then by the flip map.
   always_comb begin
      rot = corner_ff - head.turns;
      unique case (head.flip)
         FLIP_NONE: src = rot;
         FLIP_H:    src = rot ^ 2'd1;
         FLIP_V:    src = 2'd3 - rot;
         FLIP_BOTH: src = rot ^ 2'd2;
         default:   src = rot;
      endcase
      tu = (src == 2'd0 || src == 2'd3) ? head.tu0 : head.tu1;
      tv = src[1] ? head.tv1 : head.tv0;
      sx = (corner_ff == CORNER_TL || corner_ff == CORNER_BL) ? head.px0 : head.px1;
      sy = corner_ff[1] ? head.py1 : head.py0;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff <= CORNER_TL;
         valid_ff  <= 1'b0;
      end else begin
         corner_ff <= corner_in;
         valid_ff  <= valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (fire) begin
         out_corner_ff <= corner_ff;
         sx_ff         <= sx;
         sy_ff         <= sy;
         tu_ff         <= tu;
         tv_ff         <= tv;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_corner   = out_corner_ff;
   assign rsp_screen_x = $signed(sx_ff);
   assign rsp_screen_y = $signed(sy_ff);
   assign rsp_tex_u    = $signed(tu_ff);
   assign rsp_tex_v    = $signed(tv_ff);
   assign rsp_last     = (out_corner_ff == CORNER_BL);

endmodule

`default_nettype wire
